[src/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// No other dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FSTL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FSTL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Same-cycle implication that also holds during reset.
`define FSTL_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

[src/fstl_pkg.sv]
// Package of the flat Lambert triangle shader: payload types, unit request
// and response structs, register indexes, widths and the sequencer states.
// No dependencies.
package fstl_pkg;

   localparam int LIGHT_WORDS    = 4;
   localparam int MAX_LIGHTS_DEF = 4;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_FIRST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_LAST  = 3'd4;

   // Datapath widths.
   localparam int COORD_W = 32;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 66;
   localparam int VEC_W   = 67;
   localparam int MANT_W  = 30;
   localparam int SQ_W    = 62;
   localparam int ROOT_W  = 31;
   localparam int FRAC_W  = 14;
   localparam int DIVD_W  = MANT_W + FRAC_W;
   localparam int QUO_W   = FRAC_W + 1;
   localparam int UNIT_W  = 16;
   localparam int DOT_W   = 32;
   localparam int ACC_W   = 48;

   localparam logic [7:0] GRAY_MAX = 8'd255;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] first_z;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] second_z;
      logic signed [COORD_W-1:0] third_x;
      logic signed [COORD_W-1:0] third_y;
      logic signed [COORD_W-1:0] third_z;
   } req_type;

   typedef struct packed {
      logic [7:0] gray_level;
      logic       degenerate;
   } rsp_type;

   typedef struct packed {
      logic            start;
      logic [SQ_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [ROOT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CROSS, S_ABS, S_NZERO, S_NSHIFT, S_NSQ, S_SQRT_GO, S_SQRT_WAIT,
      S_DIV_GO, S_DIV_WAIT, S_NDONE, S_LNEXT, S_LLOAD, S_DOT, S_INTEN, S_OUT
   } state_type;

endpackage

[src/fstl_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on fstl_pkg.
module fstl_mul (
   input  logic                                clock,
   input  logic signed [fstl_pkg::MUL_W-1:0]   op_a,
   input  logic signed [fstl_pkg::MUL_W-1:0]   op_b,
   output logic signed [fstl_pkg::PROD_W-1:0]  prod
);
   import fstl_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;

   // Full-width signed product; one operand pair per cycle.
   assign prod_in = $signed({{(PROD_W-MUL_W){op_a[MUL_W-1]}}, op_a})
                  * $signed({{(PROD_W-MUL_W){op_b[MUL_W-1]}}, op_b});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

[src/fstl_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
// Depends on fstl_pkg.
module fstl_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  fstl_pkg::sqrt_req_type sq_req,
   output fstl_pkg::sqrt_rsp_type sq_rsp
);
   import fstl_pkg::*;

   localparam int W = 64;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] res_ff, res_in;
   logic [W-1:0] bit_ff, bit_in;
   logic [W-1:0] trial;

   assign trial = res_ff + bit_ff;

   // One digit-by-digit step per cycle, from the top bit pair down.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (sq_req.start) begin
         busy_in = 1'b1;
         rem_in  = W'(sq_req.radicand);
         res_in  = '0;
         bit_in  = W'(1) << (W - 2);
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign sq_rsp.done = done_ff;
   assign sq_rsp.root = res_ff[ROOT_W-1:0];
endmodule

[src/fstl_div.sv]
// Restoring divider, one quotient bit per cycle, for the Q1.14 components.
// Depends on fstl_pkg.
module fstl_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fstl_pkg::div_req_type dv_req,
   output fstl_pkg::div_rsp_type dv_rsp
);
   import fstl_pkg::*;

   localparam int DSR_W = ROOT_W + FRAC_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0]  dsr_ff, dsr_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [3:0]        cnt_ff, cnt_in;

   // Compare against the shifted divisor and subtract when it fits.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (dv_req.start) begin
         busy_in = 1'b1;
         rem_in  = dv_req.dividend;
         dsr_in  = {dv_req.divisor, {FRAC_W{1'b0}}};
         quo_in  = '0;
         cnt_in  = 4'(FRAC_W);
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= dsr_ff) begin
            rem_in = rem_ff - dsr_ff[DIVD_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         dsr_in = dsr_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign dv_rsp.done     = done_ff;
   assign dv_rsp.quotient = quo_ff;
endmodule

[src/flat_shade_triangle_lambert_top.sv]
// Top level of the flat Lambert triangle shader: sequencer and datapath
// registers around the shared multiplier, square root and divider units.
// Depends on fstl_pkg, fstl_mul, fstl_sqrt and fstl_div.
//
// Usage: one triangle beat (three Q16.16 vertices) enters on req_valid and
// req_ready; one result beat (gray level and degenerate flag) leaves on
// rsp_valid and rsp_ready. req_ready is high only while the sequencer is idle.
// Lights are programmed on the csr_ port while the block is idle; the block
// itself does not enforce this. The face normal comes from cross products on
// the shared multiplier, a bit-serial magnitude shift, a square root and
// three divisions; each enabled light goes through the same units for its
// own normalization, then a dot product and an intensity weight.
// The result sits in an output register; the next triangle is accepted while
// it waits, and a stalled receiver only holds the sequencer in its last state.
// Reset clears the light registers, the sequencer and the output valid.
module flat_shade_triangle_lambert_top #(
   parameter int MAX_LIGHTS = fstl_pkg::MAX_LIGHTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fstl_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fstl_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [fstl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fstl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fstl_pkg::*;

   localparam int LIM_I = (MAX_LIGHTS < LIGHT_WORDS) ? MAX_LIGHTS : LIGHT_WORDS;
   localparam logic [2:0] LIGHT_LIM = 3'(LIM_I);

   // Configuration registers.
   logic [2:0]            light_count_ff;
   logic [CSR_DATA_W-1:0] light_word_ff [LIGHT_WORDS];
   logic [CSR_IDX_W-1:0]  word_sel;

   assign word_sel = csr_index - CSR_LIGHT_FIRST;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_count_ff <= '0;
         for (int i = 0; i < LIGHT_WORDS; i++) begin
            light_word_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_LIGHT_COUNT) begin
            light_count_ff <= csr_wdata[2:0];
         end else if (csr_index >= CSR_LIGHT_FIRST && csr_index <= CSR_LIGHT_LAST) begin
            light_word_ff[word_sel[1:0]] <= csr_wdata;
         end
      end
   end

   // Sequencer and datapath registers.
   state_type                state_ff, state_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic signed [MUL_W-1:0]  v1_ff [3], v1_in [3];
   logic signed [MUL_W-1:0]  v2_ff [3], v2_in [3];
   logic [VEC_W-1:0]         vm_ff [3], vm_in [3];
   logic                     vneg_ff [3], vneg_in [3];
   logic [SQ_W-1:0]          sum_ff, sum_in;
   logic [ROOT_W-1:0]        len_ff, len_in;
   logic [1:0]               dsel_ff, dsel_in;
   logic signed [UNIT_W-1:0] vout_ff [3], vout_in [3];
   logic signed [UNIT_W-1:0] nrm_ff [3], nrm_in [3];
   logic                     is_light_ff, is_light_in;
   logic [2:0]               lidx_ff, lidx_in;
   logic [UNIT_W-1:0]        inten_ff, inten_in;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic                     deg_ff, deg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // Shared units.
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_prod;
   sqrt_req_type             sq_req;
   sqrt_rsp_type             sq_rsp;
   div_req_type              dv_req;
   div_rsp_type              dv_rsp;

   fstl_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod(mul_prod));
   fstl_sqrt u_sqrt (.clock(clock), .reset(reset), .sq_req(sq_req), .sq_rsp(sq_rsp));
   fstl_div u_div (.clock(clock), .reset(reset), .dv_req(dv_req), .dv_rsp(dv_rsp));

   // One read port into the vector under normalization.
   logic [1:0]        vsel;
   logic [MANT_W-1:0] vpick;
   assign vsel  = (state_ff == S_NSQ && cnt_ff < 3'd3) ? cnt_ff[1:0] : dsel_ff;
   assign vpick = vm_ff[vsel][MANT_W-1:0];

   assign sq_req.start    = (state_ff == S_SQRT_GO);
   assign sq_req.radicand = sum_ff;
   assign dv_req.start    = (state_ff == S_DIV_GO);
   assign dv_req.dividend = {vpick, {FRAC_W{1'b0}}};
   assign dv_req.divisor  = len_ff;

   // Multiplier operand selection by step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_CROSS: begin
            unique case (cnt_ff)
               3'd0: begin mul_a = v2_ff[1]; mul_b = v1_ff[2]; end
               3'd1: begin mul_a = v2_ff[2]; mul_b = v1_ff[1]; end
               3'd2: begin mul_a = v2_ff[2]; mul_b = v1_ff[0]; end
               3'd3: begin mul_a = v2_ff[0]; mul_b = v1_ff[2]; end
               3'd4: begin mul_a = v2_ff[0]; mul_b = v1_ff[1]; end
               3'd5: begin mul_a = v2_ff[1]; mul_b = v1_ff[0]; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         S_NSQ: begin
            mul_a = $signed({{(MUL_W-MANT_W){1'b0}}, vpick});
            mul_b = $signed({{(MUL_W-MANT_W){1'b0}}, vpick});
         end
         S_DOT: begin
            if (cnt_ff < 3'd3) begin
               mul_a = MUL_W'(nrm_ff[cnt_ff[1:0]]);
               mul_b = MUL_W'(vout_ff[cnt_ff[1:0]]);
            end
         end
         S_INTEN: begin
            mul_a = MUL_W'(dot_ff);
            mul_b = $signed({{(MUL_W-UNIT_W){1'b0}}, inten_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Lights in use and the final scaling of the accumulator.
   logic [2:0]        used;
   logic [ACC_W+7:0]  scaled;
   logic [13:0]       gray_hi;
   logic [7:0]        gray;
   logic [VEC_W-1:0]  orv;
   logic [CSR_DATA_W-1:0] lw;
   logic [1:0]        ci;
   logic [2:0]        cj;
   logic [UNIT_W-1:0] qext;
   logic [UNIT_W-1:0] lmag [3];

   assign used    = (light_count_ff > LIGHT_LIM) ? LIGHT_LIM : light_count_ff;
   assign scaled  = {acc_ff, 8'd0} - {8'd0, acc_ff};
   assign gray_hi = scaled[ACC_W+7:ACC_W-6];
   assign gray    = deg_ff ? 8'd0 : ((|gray_hi[13:8]) ? GRAY_MAX : gray_hi[7:0]);
   assign orv     = vm_ff[0] | vm_ff[1] | vm_ff[2];
   assign lw      = light_word_ff[lidx_ff[1:0]];
   assign cj      = cnt_ff - 3'd1;
   assign ci      = cj[2:1];
   assign qext    = {1'b0, dv_rsp.quotient};

   // Magnitudes of the light direction components, formed at 16 bits.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lmag[i] = lw[16*i+15] ? (~lw[16*i +: 16] + 16'd1) : lw[16*i +: 16];
      end
   end

   // Next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      vm_in        = vm_ff;
      vneg_in      = vneg_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      dsel_in      = dsel_ff;
      vout_in      = vout_ff;
      nrm_in       = nrm_ff;
      is_light_in  = is_light_ff;
      lidx_in      = lidx_ff;
      inten_in     = inten_ff;
      dot_in       = dot_ff;
      acc_in       = acc_ff;
      deg_in       = deg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               v1_in[0]    = MUL_W'(req_data.second_x) - MUL_W'(req_data.first_x);
               v1_in[1]    = MUL_W'(req_data.second_y) - MUL_W'(req_data.first_y);
               v1_in[2]    = MUL_W'(req_data.second_z) - MUL_W'(req_data.first_z);
               v2_in[0]    = MUL_W'(req_data.third_x) - MUL_W'(req_data.second_x);
               v2_in[1]    = MUL_W'(req_data.third_y) - MUL_W'(req_data.second_y);
               v2_in[2]    = MUL_W'(req_data.third_z) - MUL_W'(req_data.second_z);
               cnt_in      = '0;
               acc_in      = '0;
               deg_in      = 1'b0;
               lidx_in     = '0;
               is_light_in = 1'b0;
               state_in    = S_CROSS;
            end
         end
         // Cross product as three differences of products.
         S_CROSS: begin
            if (cnt_ff != '0) begin
               if (!cj[0]) begin
                  vm_in[ci] = VEC_W'(mul_prod);
               end else begin
                  vm_in[ci] = vm_ff[ci] - VEC_W'(mul_prod);
               end
            end
            if (cnt_ff == 3'd6) begin
               cnt_in   = '0;
               state_in = S_ABS;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         S_ABS: begin
            for (int i = 0; i < 3; i++) begin
               vneg_in[i] = vm_ff[i][VEC_W-1];
               vm_in[i]   = vm_ff[i][VEC_W-1] ? -vm_ff[i] : vm_ff[i];
            end
            state_in = S_NZERO;
         end
         S_NZERO: begin
            if (orv == '0) begin
               if (is_light_ff) begin
                  state_in = S_LNEXT;
               end else begin
                  deg_in   = 1'b1;
                  state_in = S_OUT;
               end
            end else begin
               state_in = S_NSHIFT;
            end
         end
         // Bring the largest magnitude to exactly 30 bits, one bit a cycle.
         S_NSHIFT: begin
            if (|orv[VEC_W-1:MANT_W]) begin
               for (int i = 0; i < 3; i++) vm_in[i] = vm_ff[i] >> 1;
            end else if (!orv[MANT_W-1]) begin
               for (int i = 0; i < 3; i++) vm_in[i] = vm_ff[i] << 1;
            end else begin
               cnt_in   = '0;
               sum_in   = '0;
               state_in = S_NSQ;
            end
         end
         S_NSQ: begin
            if (cnt_ff != '0) begin
               sum_in = sum_ff + mul_prod[SQ_W-1:0];
            end
            if (cnt_ff == 3'd3) begin
               state_in = S_SQRT_GO;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         S_SQRT_GO: begin
            state_in = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (sq_rsp.done) begin
               len_in   = sq_rsp.root;
               dsel_in  = '0;
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (dv_rsp.done) begin
               vout_in[dsel_ff] = vneg_ff[dsel_ff] ? -$signed(qext) : $signed(qext);
               if (dsel_ff == 2'd2) begin
                  state_in = S_NDONE;
               end else begin
                  dsel_in  = dsel_ff + 2'd1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_NDONE: begin
            if (is_light_ff) begin
               cnt_in   = '0;
               dot_in   = '0;
               state_in = S_DOT;
            end else begin
               nrm_in   = vout_ff;
               state_in = S_LNEXT;
            end
         end
         S_LNEXT: begin
            state_in = (lidx_ff < used) ? S_LLOAD : S_OUT;
         end
         // Negated light direction as magnitudes and signs.
         S_LLOAD: begin
            for (int i = 0; i < 3; i++) begin
               vm_in[i]   = VEC_W'(lmag[i]);
               vneg_in[i] = !lw[16*i+15] && (lw[16*i +: 16] != '0);
            end
            inten_in    = lw[63:48];
            is_light_in = 1'b1;
            lidx_in     = lidx_ff + 3'd1;
            state_in    = S_NZERO;
         end
         S_DOT: begin
            if (cnt_ff != '0) begin
               dot_in = dot_ff + $signed(mul_prod[DOT_W-1:0]);
            end
            if (cnt_ff == 3'd3) begin
               cnt_in   = '0;
               state_in = S_INTEN;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         // Weight a positive cosine by the intensity.
         S_INTEN: begin
            if (cnt_ff == '0) begin
               if (!dot_ff[DOT_W-1] && dot_ff != '0) begin
                  cnt_in = 3'd1;
               end else begin
                  state_in = S_LNEXT;
               end
            end else begin
               acc_in   = acc_ff + mul_prod[ACC_W-1:0];
               cnt_in   = '0;
               state_in = S_LNEXT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.gray_level = gray;
               rsp_data_in.degenerate = deg_ff;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      v1_ff       <= v1_in;
      v2_ff       <= v2_in;
      vm_ff       <= vm_in;
      vneg_ff     <= vneg_in;
      sum_ff      <= sum_in;
      len_ff      <= len_in;
      dsel_ff     <= dsel_in;
      vout_ff     <= vout_in;
      nrm_ff      <= nrm_in;
      is_light_ff <= is_light_in;
      lidx_ff     <= lidx_in;
      inten_ff    <= inten_in;
      dot_ff      <= dot_in;
      acc_ff      <= acc_in;
      deg_ff      <= deg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

[src/fstl_checker.sv]
// Port-level checker for the flat Lambert triangle shader, bound to the top.
// Depends on fstl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fstl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input fstl_pkg::rsp_type rsp_data
);
   import fstl_pkg::*;

   // The block is busy in the cycle after it takes a triangle beat.
   `FSTL_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // A stalled result beat holds.
   `FSTL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A degenerate face is always dark.
   `FSTL_ASSERT_IMP(a_degenerate_dark, clock, reset, rsp_valid && rsp_data.degenerate, rsp_data.gray_level == 8'd0)

   // Reset leaves no result pending in the following cycle.
   `FSTL_ASSERT_ALWAYS(a_reset_clears, clock, reset, ##1 !rsp_valid)
endmodule

bind flat_shade_triangle_lambert_top fstl_checker u_fstl_checker (.*);
